// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/brcs_pkg.sv =====
package brcs_pkg;

    localparam int unsigned CFG_AW = 3;
    localparam int unsigned LEN_W  = 30;
    localparam int unsigned CNT_W  = 33;
    localparam int unsigned POS_W  = 34;

    // register indexes
    localparam logic [CFG_AW-1:0] CFG_STRING_LENGTH = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_RANGE_START   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RANGE_STOP    = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_SEEK_BIT      = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_STOP_EXPLICIT = 3'd4;

    // longest string handled; longer lengths clamp to this
    localparam logic [LEN_W-1:0] MAX_BYTES = 30'd536870912;
    // byte index saturates here
    localparam logic [LEN_W-1:0] IDX_MAX   = 30'h3FFF_FFFF;

    typedef struct packed {
        logic [LEN_W-1:0] string_length;
        logic [LEN_W-1:0] range_start;    // two's complement
        logic [LEN_W-1:0] range_stop;     // two's complement
        logic             seek_bit;
        logic             stop_explicit;
    } t_cfg;

    // one classified byte, front to back
    typedef struct packed {
        logic             is_last;
        logic             in_range;
        logic [3:0]       pop;          // set bits of the byte
        logic             hit;          // byte holds a bit equal to seek_bit
        logic [2:0]       bit_ofs;      // offset of that bit from the MSB
        logic [LEN_W-1:0] idx;          // byte index in the string
        logic             cnt_zero;     // both indices negative, start after stop
        logic [POS_W-1:0] pos_nomatch;  // position to report when nothing matched
    } t_entry;

endpackage

// ===== rtl/core/bitmap_range_count_and_seek.sv =====
// Bitmap range count and seek. Bytes of a bitmap string arrive on the slave stream, one per
// request, tlast on the final byte. The configured start/stop byte indices (negative counts
// back from string_length, clamped to the string) select a range; the block counts the set
// bits in it and finds the first bit equal to seek_bit, MSB first, reporting its bit index
// from the string start (-1 if none; when seeking zero with no match and no explicit stop,
// the padded end). One result request leaves per tlast byte. Throughput is one byte per
// clock: the front classifies each byte (range compare, popcount, priority encode) in the
// cycle it is accepted, a two-entry queue hands it to the back, and the back's single
// 33-bit accumulate sets the rate. A last byte passes through the queue to the back, which
// registers its result in an output register for the master side; while it waits, bytes keep flowing
// until the next last byte reaches the back, one more byte queues behind that, and then the
// slave side stalls. Registers may be written only while no string is in flight.
`include "assert_macros.svh"

module bitmap_range_count_and_seek import brcs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // slave side: tdata = byte_value[7:0]
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [7:0]        i_s_tdata,
    input  logic              i_s_tlast,     // is_last
    // master side: tdata = bit_count[32:0], first_position[66:33], zero pad [71:67]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [71:0]       o_m_tdata,
    // register writes
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [LEN_W-1:0]  i_cfg_wdata
);

    t_cfg             r_cfg;
    logic             push;
    logic             q_ready;
    t_entry           f_entry;
    t_entry           q_entry;
    logic             q_valid;
    logic             q_pop;
    logic [CNT_W-1:0] bit_count;
    logic [POS_W-1:0] first_position;

    // register file; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.string_length <= '0;
            r_cfg.range_start   <= '0;
            r_cfg.range_stop    <= '1;
            r_cfg.seek_bit      <= 1'b1;
            r_cfg.stop_explicit <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_STRING_LENGTH: r_cfg.string_length <= i_cfg_wdata;
                CFG_RANGE_START:   r_cfg.range_start   <= i_cfg_wdata;
                CFG_RANGE_STOP:    r_cfg.range_stop    <= i_cfg_wdata;
                CFG_SEEK_BIT:      r_cfg.seek_bit      <= i_cfg_wdata[0];
                CFG_STOP_EXPLICIT: r_cfg.stop_explicit <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // classify each byte against the range
    brcs_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_last    (i_s_tlast),
        .i_q_ready (q_ready),
        .o_push    (push),
        .o_entry   (f_entry)
    );

    // decouples the classifier from the accumulator
    brcs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_ready (q_ready),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // accumulate, track first match, build the result
    brcs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (q_valid),
        .i_entry          (q_entry),
        .o_pop            (q_pop),
        .o_valid          (o_m_tvalid),
        .i_ready          (i_m_tready),
        .o_bit_count      (bit_count),
        .o_first_position (first_position)
    );

    assign o_m_tdata = {5'b00000, first_position, bit_count};

    // a byte is only taken when the queue has room
    `ASSERT_IMP(a_top_room, i_clk, i_rst_n, i_s_tvalid && o_s_tready, q_ready, "byte taken into full queue")

endmodule

// ===== rtl/core/brcs_front.sv =====
module brcs_front import brcs_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    input  logic       i_q_ready,
    output logic       o_push,
    output t_entry     o_entry
);

    logic [LEN_W-1:0]  r_idx;
    logic [LEN_W-1:0]  len;
    logic signed [31:0] len_s;
    logic signed [31:0] a_s;
    logic signed [31:0] b_s;
    logic signed [31:0] idx_s;
    logic signed [31:0] bi_s;
    logic signed [31:0] first_s;
    logic signed [31:0] e_inc;
    logic [7:0]        x;
    logic [2:0]        k;
    logic [3:0]        pop;

    always_comb begin
        len   = (i_cfg.string_length > MAX_BYTES) ? MAX_BYTES : i_cfg.string_length;
        len_s = signed'({2'b00, len});

        a_s = signed'({{2{i_cfg.range_start[LEN_W-1]}}, i_cfg.range_start});
        if (a_s < 0) begin
            a_s = a_s + len_s;
        end
        if (a_s < 0) begin
            a_s = 32'sd0;
        end

        b_s = signed'({{2{i_cfg.range_stop[LEN_W-1]}}, i_cfg.range_stop});
        if (b_s < 0) begin
            b_s = b_s + len_s;
        end
        if (b_s < 0) begin
            b_s = 32'sd0;
        end
        if (b_s >= len_s) begin
            b_s = len_s - 32'sd1;
        end

        idx_s = signed'({2'b00, r_idx});
        bi_s  = (r_idx == IDX_MAX) ? idx_s : idx_s + 32'sd1;
        first_s = (bi_s > a_s) ? bi_s : a_s;
        e_inc   = b_s + 32'sd1;

        x   = i_cfg.seek_bit ? i_byte : ~i_byte;
        k   = 3'd0;
        pop = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (x[i]) begin
                k = 3'(7 - i);   // highest set bit wins
            end
            pop = pop + 4'(i_byte[i]);
        end

        o_entry.is_last  = i_last;
        o_entry.in_range = (idx_s >= a_s) && (idx_s <= b_s);
        o_entry.pop      = pop;
        o_entry.hit      = |x;
        o_entry.bit_ofs  = k;
        o_entry.idx      = r_idx;
        o_entry.cnt_zero = i_cfg.range_start[LEN_W-1] && i_cfg.range_stop[LEN_W-1]
                           && ($signed(i_cfg.range_start) > $signed(i_cfg.range_stop));

        if ((a_s > b_s) || i_cfg.seek_bit) begin
            o_entry.pos_nomatch = '1;
        end else if (bi_s <= b_s) begin
            // seeking zero, range not fully delivered: first missing byte
            o_entry.pos_nomatch = {first_s[30:0], 3'b000};
        end else if (i_cfg.stop_explicit) begin
            o_entry.pos_nomatch = '1;
        end else begin
            o_entry.pos_nomatch = {e_inc[30:0], 3'b000};
        end
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (o_push) begin
            if (i_last) begin
                r_idx <= '0;
            end else if (r_idx != IDX_MAX) begin
                r_idx <= r_idx + 30'd1;
            end
        end
    end

endmodule

// ===== rtl/core/brcs_queue.sv =====
`include "assert_macros.svh"

module brcs_queue import brcs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_ready,
    input  logic   i_pop,
    output logic   o_valid,
    output t_entry o_entry
);

    localparam logic [1:0] DEPTH = 2'd2;

    t_entry     r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_count;

    assign o_ready = (r_count != DEPTH);
    assign o_valid = (r_count != 2'd0);
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= DEPTH, "queue overfilled")
    `ASSERT_NXT(a_q_pass, i_clk, i_rst_n, i_push && i_pop, $stable(r_count), "queue count moved")

endmodule

// ===== rtl/core/brcs_back.sv =====
`include "assert_macros.svh"

module brcs_back import brcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_entry           i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CNT_W-1:0] o_bit_count,
    output logic [POS_W-1:0] o_first_position
);

    logic [CNT_W-1:0] r_acc;
    logic             r_found;
    logic [CNT_W-1:0] r_mpos;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_out_count;
    logic [POS_W-1:0] r_out_pos;

    logic [CNT_W-1:0] sum;
    logic             new_hit;
    logic [CNT_W-1:0] mpos_here;

    // a non-final byte never waits on the output register
    assign o_pop = i_valid && (!i_entry.is_last || !r_out_valid || i_ready);

    assign sum       = r_acc + (i_entry.in_range ? CNT_W'(i_entry.pop) : '0);
    assign new_hit   = i_entry.in_range && i_entry.hit && !r_found;
    assign mpos_here = {i_entry.idx, i_entry.bit_ofs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                if (i_entry.is_last) begin
                    r_acc       <= '0;
                    r_found     <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_acc <= sum;
                    if (new_hit) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && !i_entry.is_last && new_hit) begin
            r_mpos <= mpos_here;
        end
        if (o_pop && i_entry.is_last) begin
            r_out_count <= i_entry.cnt_zero ? '0 : sum;
            if (r_found) begin
                r_out_pos <= {1'b0, r_mpos};
            end else if (new_hit) begin
                r_out_pos <= {1'b0, mpos_here};
            end else begin
                r_out_pos <= i_entry.pos_nomatch;
            end
        end
    end

    assign o_valid          = r_out_valid;
    assign o_bit_count      = r_out_count;
    assign o_first_position = r_out_pos;

    `ASSERT_NXT(a_back_clear, i_clk, i_rst_n, o_pop && i_entry.is_last, (r_acc == '0) && !r_found, "stream state not cleared")

endmodule

// ===== sim/bitmap_range_count_and_seek_tb.sv =====
`timescale 1ns / 1ps

module bitmap_range_count_and_seek_tb;
    import brcs_pkg::*;

    // ---------------------------------------------------------------------
    // Run shape
    // ---------------------------------------------------------------------
    localparam int RAND_BYTES  = 1150;   // random byte requests after the table
    localparam int SETTLE      = 8;      // wait after the last expected result before the registers change
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off
    localparam int IDLE_LIMIT  = 4000;   // cycles without any request moving
    localparam int N_DIR       = 12;

    // indexes past the last register, written to check they are ignored
    localparam logic [CFG_AW-1:0] CFG_SPARE = CFG_STOP_EXPLICIT + 3'd1;

    localparam logic [POS_W-1:0] NO_POS = '1;   // first_position of -1

    // ---------------------------------------------------------------------
    // DUT ports; every input is known from time zero
    // ---------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [7:0]        i_s_tdata   = '0;     // byte_value[7:0]
    logic              i_s_tlast   = 1'b0;   // is_last
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [71:0]       o_m_tdata;            // bit_count[32:0], first_position[66:33], pad
    logic              i_cfg_we    = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr  = '0;
    logic [LEN_W-1:0]  i_cfg_wdata = '0;

    bitmap_range_count_and_seek u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------
    // Shadow registers and scan state of the predictor
    // ---------------------------------------------------------------------
    logic [LEN_W-1:0] cfg_len   = '0;
    logic [LEN_W-1:0] cfg_start = '0;
    logic [LEN_W-1:0] cfg_stop  = '1;
    logic             cfg_seek  = 1'b1;
    logic             cfg_expl  = 1'b0;

    logic [LEN_W-1:0] byte_idx  = '0;
    logic [CNT_W-1:0] run_count = '0;
    logic             hit_seen  = 1'b0;
    logic [CNT_W-1:0] hit_pos   = '0;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [POS_W-1:0] pos;
    } range_result_t;

    range_result_t pending_results [$];

    int err_cnt      = 0;
    int bytes_sent   = 0;
    int strings_sent = 0;
    int results_seen = 0;
    int settings     = 0;

    bit tx_no_idle = 1'b0;
    bit rx_no_idle = 1'b0;
    bit hold_req   = 1'b0;

    // ---------------------------------------------------------------------
    // Predictor: consumes one byte, returns 1 with the result on the last one
    // ---------------------------------------------------------------------
    function automatic bit scan_byte(input logic [7:0] b, input logic last,
                                     output range_result_t res);
        longint len, s, e, idx, first, pos;
        logic [7:0] x;
        int k;
        res = '0;
        len = (cfg_len > MAX_BYTES) ? longint'(MAX_BYTES) : longint'(cfg_len);
        s = $signed(cfg_start);
        e = $signed(cfg_stop);
        if (s < 0) s += len;
        if (e < 0) e += len;
        if (s < 0) s = 0;
        if (e < 0) e = 0;
        if (e >= len) e = len - 1;

        idx = longint'(byte_idx);
        if (idx >= s && idx <= e) begin
            x = cfg_seek ? b : ~b;
            run_count = run_count + CNT_W'($countones(b));
            if (!hit_seen && x != 8'h00) begin
                k = 0;
                while (!x[7-k]) k++;   // MSB first
                hit_pos  = CNT_W'(idx * 8 + k);
                hit_seen = 1'b1;
            end
        end
        if (byte_idx != IDX_MAX) byte_idx++;

        if (!last) return 1'b0;

        // both indices negative with start past stop: count forced to zero
        if ($signed(cfg_start) < 0 && $signed(cfg_stop) < 0 &&
            $signed(cfg_start) > $signed(cfg_stop))
            res.count = '0;
        else
            res.count = run_count;

        if (s > e) begin
            pos = -1;
        end else if (hit_seen) begin
            pos = longint'(hit_pos);
        end else if (cfg_seek) begin
            pos = -1;
        end else if (longint'(byte_idx) <= e) begin
            // short stream: missing bytes read as zero
            first = (longint'(byte_idx) > s) ? longint'(byte_idx) : s;
            pos = first * 8;
        end else if (cfg_expl) begin
            pos = -1;
        end else begin
            pos = (e + 1) * 8;   // padded end
        end
        res.pos = pos[POS_W-1:0];

        byte_idx  = '0;
        run_count = '0;
        hit_seen  = 1'b0;
        hit_pos   = '0;
        return 1'b1;
    endfunction

    // ---------------------------------------------------------------------
    // Random helpers
    // ---------------------------------------------------------------------
    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 8'h00;
        if (r < 40) return 8'hFF;
        if (r < 55) return 8'h80 >> $urandom_range(0, 7);
        return 8'($urandom);
    endfunction

    // start/stop index: mostly near the string, sometimes extreme or wild
    function automatic logic [LEN_W-1:0] rand_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return LEN_W'($urandom_range(0, 28)) - LEN_W'(14);
        if (r < 80) return $urandom_range(0, 1) ? 30'h2000_0000 : 30'h1FFF_FFFF;
        return LEN_W'($urandom);
    endfunction

    function automatic logic [LEN_W-1:0] rand_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return '0;
        if (r < 80) return LEN_W'($urandom_range(1, 12));
        if (r < 88) return MAX_BYTES;
        if (r < 94) return LEN_W'($urandom_range(MAX_BYTES, IDX_MAX));
        return LEN_W'($urandom_range(13, 20));
    endfunction

    // ---------------------------------------------------------------------
    // Mismatch report
    // ---------------------------------------------------------------------
    task automatic report(input string what, input logic [POS_W-1:0] got,
                          input logic [POS_W-1:0] want);
        if (err_cnt < 40)
            $display("%0t ns: %s mismatch, got %h want %h", $realtime, what, got, want);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------------
    // Register load: one write per cycle, enable held high across the burst
    // ---------------------------------------------------------------------
    task automatic load_config(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] start,
                               input logic [LEN_W-1:0] stop, input logic seek,
                               input logic expl, input bit noise);
        logic [LEN_W-1:0] junk;
        junk = noise ? LEN_W'($urandom) : '0;
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_STRING_LENGTH;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RANGE_START;
        i_cfg_wdata <= start;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RANGE_STOP;
        i_cfg_wdata <= stop;
        @(posedge i_clk);
        // single-bit registers only look at bit 0
        i_cfg_addr  <= CFG_SEEK_BIT;
        i_cfg_wdata <= {junk[LEN_W-1:1], seek};
        @(posedge i_clk);
        i_cfg_addr  <= CFG_STOP_EXPLICIT;
        i_cfg_wdata <= {junk[LEN_W-1:2], junk[0], expl};
        @(posedge i_clk);
        if (noise) begin
            // unmapped index: must leave every register alone
            i_cfg_addr  <= CFG_SPARE + CFG_AW'($urandom_range(0, 2));
            i_cfg_wdata <= LEN_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        cfg_len   = len;
        cfg_start = start;
        cfg_stop  = stop;
        cfg_seek  = seek;
        cfg_expl  = expl;
        settings++;
    endtask

    // ---------------------------------------------------------------------
    // Byte request: optional gap, then hold valid until accepted. Valid is
    // left high afterwards so back-to-back requests never toggle it.
    // ---------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last,
                             input bit typed, input range_result_t typed_res);
        int gap;
        range_result_t res;
        gap = tx_no_idle ? 0 : pick_gap();
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        if (scan_byte(b, last, res))
            pending_results.push_back(typed ? typed_res : res);
        bytes_sent++;
        if (last) strings_sent++;
    endtask

    // stop sending, let every expected result arrive, then let the pipe settle
    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // Result side: check each accepted result, then pick next tready
    // ---------------------------------------------------------------------
    task automatic check_result();
        range_result_t want;
        logic [CNT_W-1:0] got_cnt;
        logic [POS_W-1:0] got_pos;
        got_cnt = o_m_tdata[CNT_W-1:0];
        got_pos = o_m_tdata[CNT_W +: POS_W];
        results_seen++;
        if (pending_results.size() == 0) begin
            report("unexpected result", got_pos, NO_POS);
        end else begin
            want = pending_results.pop_front();
            if (got_cnt !== want.count)
                report("bit_count", POS_W'(got_cnt), POS_W'(want.count));
            if (got_pos !== want.pos)
                report("first_position", got_pos, want.pos);
        end
    endtask

    initial begin : rx_side
        int stall_left;
        int hold_left;
        int g;
        stall_left = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) check_result();
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (rx_no_idle) begin
                i_m_tready <= 1'b1;
            end else begin
                g = pick_gap();
                if (g == 0) begin
                    i_m_tready <= 1'b1;
                end else begin
                    i_m_tready <= 1'b0;
                    stall_left = g - 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Watchdog: any stretch with no request moving on either side
    // ---------------------------------------------------------------------
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t ns: no progress for %0d cycles", $realtime, IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Directed strings. Bytes go out low byte of data first. Typed rows carry
    // a result obvious from the settings; the rest use the predictor.
    // ---------------------------------------------------------------------
    typedef struct {
        bit               wr;       // load registers before the string
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] stop;
        logic             seek;
        logic             expl;
        int               nb;
        logic [31:0]      data;
        bit               typed;
        logic [CNT_W-1:0] cnt;
        logic [POS_W-1:0] pos;
    } dir_row_t;

    dir_row_t dir_tab [N_DIR] = '{
        // reset settings: zero-length string, everything ignored
        '{1'b0, 30'd0, 30'd0, -30'sd1, 1'b1, 1'b0, 1, 32'h0000_00FF, 1'b1, 33'd0, NO_POS},
        // last bit of a two-byte string
        '{1'b1, 30'd4, 30'd0, -30'sd1, 1'b1, 1'b0, 2, 32'h0000_0100, 1'b1, 33'd1, 34'd15},
        // both negative, start after stop, clamped to byte 0: count zero, pos kept
        '{1'b1, 30'd4, -30'sd5, -30'sd6, 1'b1, 1'b0, 2, 32'h0000_FF10, 1'b1, 33'd0, 34'd3},
        // seek zero, none found, explicit stop
        '{1'b1, 30'd2, 30'd0, 30'd1, 1'b0, 1'b1, 2, 32'h0000_FFFF, 1'b1, 33'd16, NO_POS},
        // seek zero, none found, padded end
        '{1'b1, 30'd2, 30'd0, 30'd1, 1'b0, 1'b0, 2, 32'h0000_FFFF, 1'b1, 33'd16, 34'd16},
        // stream ends early while seeking zero: first missing byte
        '{1'b1, 30'd4, 30'd0, -30'sd1, 1'b0, 1'b0, 1, 32'h0000_00FF, 1'b1, 33'd8, 34'd8},
        // bytes past the string length are ignored
        '{1'b1, 30'd1, 30'd0, -30'sd1, 1'b1, 1'b0, 3, 32'h00FF_FF00, 1'b1, 33'd0, NO_POS},
        // oversized length clamps to the maximum string
        '{1'b1, 30'h3FFF_FFFF, -30'sd1, -30'sd1, 1'b0, 1'b0, 1, 32'h0000_0000,
          1'b1, 33'd0, 34'h0_FFFF_FFF8},
        // most negative start, most positive stop
        '{1'b1, 30'd3, 30'h2000_0000, 30'h1FFF_FFFF, 1'b1, 1'b0, 3, 32'h00FF_0080,
          1'b1, 33'd9, 34'd0},
        // most positive start, most negative stop: empty range
        '{1'b1, 30'd3, 30'h1FFF_FFFF, 30'h2000_0000, 1'b1, 1'b0, 1, 32'h0000_00FF,
          1'b1, 33'd0, NO_POS},
        '{1'b1, 30'd3, 30'd0, -30'sd1, 1'b1, 1'b0, 3, 32'h0040_0000, 1'b0, 33'd0, 34'd0},
        '{1'b1, MAX_BYTES, 30'd0, -30'sd1, 1'b0, 1'b1, 2, 32'h0000_FFFF, 1'b0, 33'd0, 34'd0}
    };

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : tx_side
        range_result_t typed_res;
        int phase;
        int n_str;
        int n;
        int r;
        int eff;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int row = 0; row < N_DIR; row++) begin
            if (dir_tab[row].wr) begin
                drain();
                load_config(dir_tab[row].len, dir_tab[row].start, dir_tab[row].stop,
                            dir_tab[row].seek, dir_tab[row].expl, 1'b0);
            end
            typed_res.count = dir_tab[row].cnt;
            typed_res.pos   = dir_tab[row].pos;
            for (int k = 0; k < dir_tab[row].nb; k++)
                send_byte(dir_tab[row].data[8*k +: 8], k == dir_tab[row].nb - 1,
                          dir_tab[row].typed, typed_res);
        end

        // Random phases: new settings, then a batch of strings that mostly
        // match the configured length, some short, some overlong.
        phase = 0;
        typed_res = '0;
        while (bytes_sent < RAND_BYTES + 23) begin
            drain();   // every result in before the registers change
            load_config(rand_length(), rand_index(), rand_index(),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                        $urandom_range(0, 3) == 0);
            if (phase == 2) begin
                // back-pressure: receiver holds off, sender keeps pushing short
                // strings so the output register and byte queue fill and input stalls
                tx_no_idle = 1'b1;
                rx_no_idle = 1'b0;
                hold_req   = 1'b1;
                n_str      = 40;
            end else begin
                tx_no_idle = ($urandom_range(0, 5) == 0);
                rx_no_idle = tx_no_idle;
                n_str      = $urandom_range(4, 14);
            end

            eff = (cfg_len > 30'd20) ? -1 : int'(cfg_len);
            for (int si = 0; si < n_str; si++) begin
                if (phase == 2) begin
                    n = $urandom_range(1, 2);
                end else if (eff == 0) begin
                    n = $urandom_range(1, 4);
                end else if (eff < 0) begin
                    n = $urandom_range(1, 10);   // huge string, always cut short
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 75)      n = eff;
                    else if (r < 88) n = $urandom_range(1, eff);
                    else             n = eff + $urandom_range(1, 3);
                end
                for (int k = 0; k < n; k++)
                    send_byte(rand_byte(), k == n - 1, 1'b0, typed_res);
            end
            phase++;
        end

        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        drain();

        $display("Run covered %0d strings, %0d bytes, %0d register settings and a %0d-cycle hold-off.",
                 strings_sent, bytes_sent, settings, HOLD_CYCLES);
        $display("%0d results checked, %0d mismatches.", results_seen, err_cnt);
        if (err_cnt == 0 && pending_results.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
